// ===== hdl/tdw_pkg.sv =====
// Shared types and constants of the task delay wakeup table.
`default_nettype none

package tdw_pkg;

	localparam int ACTION_W   = 2;
	localparam int TASK_W     = 3;
	localparam int PRIO_W     = 2;
	localparam int TICKS_W    = 32;
	localparam int ACTIVE_W   = 4;
	localparam int MAX_RESULTS = 8;
	localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);

	localparam logic [ACTION_W-1:0] ACT_SLEEP = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WAIT  = 2'd2;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic                start;
		logic                step;
		logic                sleep_we;
		logic                wait_we;
		logic [TASK_W-1:0]   task_sel;
		logic [TICKS_W-1:0]  ticks;
		logic [PRIO_W-1:0]   prio;
		logic                flag;
		logic [ACTIVE_W-1:0] active;
	} tdw_cmd_t;

	// Status of one cell, seen by its neighbour and by the controller.
	typedef struct packed {
		logic              tok;
		logic              wake;
		logic [PRIO_W-1:0] prio;
	} tdw_cell_st_t;

endpackage

`default_nettype wire

// ===== hdl/tdw_cell.sv =====
// One task slot of the wakeup chain: sleep state, countdown and walk token.
`default_nettype none

module tdw_cell import tdw_pkg::*; #(
	parameter int INDEX = 0
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tdw_cmd_t     cmd,
	input  wire logic         tok_in,
	output tdw_cell_st_t      st
);

	logic                sleeping_q;
	logic                ewait_q;
	logic                tok_q;
	logic [TICKS_W-1:0]  rem_q;
	logic [PRIO_W-1:0]   prio_q;
	logic                sel;
	logic                active;
	logic                counting;

	assign sel      = (int'(cmd.task_sel) == INDEX);
	assign active   = (int'(cmd.active) > INDEX);
	assign counting = tok_q && active && sleeping_q && !ewait_q;

	assign st.tok  = tok_q;
	assign st.wake = counting && (rem_q == TICKS_W'(1));
	assign st.prio = prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleeping_q <= 1'b0;
			ewait_q    <= 1'b0;
			tok_q      <= 1'b0;
		end else begin
			if (cmd.start || cmd.step) begin
				tok_q <= tok_in;
			end
			if (cmd.sleep_we && sel) begin
				sleeping_q <= 1'b1;
			end else if (cmd.step && st.wake) begin
				sleeping_q <= 1'b0;
			end
			if (cmd.wait_we && sel) begin
				ewait_q <= cmd.flag;
			end
		end
	end

	// The count and priority are only looked at while the slot is sleeping.
	always_ff @(posedge clk) begin
		if (cmd.sleep_we && sel) begin
			rem_q  <= cmd.ticks;
			prio_q <= cmd.prio;
		end else if (cmd.step && counting) begin
			rem_q <= rem_q - TICKS_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/task_delay_wakeup_table_core.sv =====
// Top level of the task delay wakeup table: controller, cell chain and ports.
// A sleep or set-wait transaction gives its single result in the cycle after acceptance; one such
// transaction can be taken every cycle while the receiver takes each result.
// A tick walks a token along the MAX_TASKS cells, one per cycle while the output register is free,
// and then closes in a finish state that loads its final result; the next transaction waits for it.
// arst_n clears the tick counter, all sleep and wait flags and the active task count at once.
`default_nettype none

module task_delay_wakeup_table_core import tdw_pkg::*; #(
	parameter int MAX_TASKS       = 8,
	parameter int PRIORITY_LEVELS = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Input channel.
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [TASK_W-1:0]   task_req,
	input  wire logic [TICKS_W-1:0]  ticks,
	input  wire logic [PRIO_W-1:0]   priority_req,
	input  wire logic                wait_flag,
	// Output channel.
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     woken_valid,
	output logic [TASK_W-1:0]        woken_task,
	output logic [PRIO_W-1:0]        woken_priority,
	output logic                     last,
	output logic [TICKS_W-1:0]       tick_count,
	// Configuration channel.
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [ACTIVE_W-1:0] active_tasks
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [TICKS_W-1:0]  elapsed_q;
	logic [RES_CNT_W-1:0] n_q;

	// A wake that has been found but not yet sent; it is held back until the next wake or the close of
	// the tick, so that the final result of a tick can carry the last flag.
	logic                pend_valid_q;
	logic [TASK_W-1:0]   pend_task_q;
	logic [PRIO_W-1:0]   pend_prio_q;

	logic                out_valid_q;
	logic                out_woken_q;
	logic [TASK_W-1:0]   out_task_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic                out_last_q;
	logic [TICKS_W-1:0]  out_tick_q;

	logic                slot_free;
	logic                accept;
	logic                is_tick;
	logic                step;
	logic [PRIO_W-1:0]   prio_sat;
	logic                wake_any;
	logic [TASK_W-1:0]   wake_task;
	logic [PRIO_W-1:0]   wake_prio;

	tdw_cmd_t            cmd;
	tdw_cell_st_t        cell_st [MAX_TASKS];

	// The output register is free when it is empty or its content leaves now.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign is_tick   = (action == ACT_TICK);
	assign step      = (state_q == ST_WALK) && slot_free;
	assign cfg_ready = 1'b1;

	// Priorities beyond the configured number of levels go to the highest level.
	assign prio_sat = (int'(priority_req) >= PRIORITY_LEVELS) ?
	                  PRIO_W'(PRIORITY_LEVELS - 1) : priority_req;

	always_comb begin
		cmd.start    = accept && is_tick;
		cmd.step     = step;
		cmd.sleep_we = accept && (action == ACT_SLEEP) && (ticks != '0);
		cmd.wait_we  = accept && (action == ACT_WAIT);
		cmd.task_sel = task_req;
		cmd.ticks    = ticks;
		cmd.prio     = prio_sat;
		cmd.flag     = wait_flag;
		cmd.active   = active_q;
	end

	// The token is in exactly one cell during a walk, so the wake reports can be
	// merged with a plain OR over the chain.
	always_comb begin
		wake_any  = 1'b0;
		wake_task = '0;
		wake_prio = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (cell_st[i].wake) begin
				wake_any  = 1'b1;
				wake_task = wake_task | TASK_W'(i);
				wake_prio = wake_prio | cell_st[i].prio;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_TASKS; g++) begin : g_cell
			tdw_cell #(
				.INDEX (g)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.tok_in ((g == 0) ? cmd.start : cell_st[(g == 0) ? 0 : g - 1].tok),
				.st     (cell_st[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= active_tasks;
		end
	end

	// Each branch decides the output register's valid flag on its own: it is loaded,
	// emptied when its content leaves, or held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elapsed_q    <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_task_q  <= '0;
			pend_prio_q  <= '0;
			out_valid_q  <= 1'b0;
			out_woken_q  <= 1'b0;
			out_task_q   <= '0;
			out_prio_q   <= '0;
			out_last_q   <= 1'b0;
			out_tick_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_tick) begin
							// The output register is free at acceptance, so it empties.
							elapsed_q    <= elapsed_q + TICKS_W'(1);
							out_tick_q   <= elapsed_q + TICKS_W'(1);
							out_valid_q  <= 1'b0;
							n_q          <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_WALK;
						end else begin
							out_valid_q <= 1'b1;
							out_woken_q <= 1'b0;
							out_task_q  <= '0;
							out_prio_q  <= '0;
							out_last_q  <= 1'b1;
							out_tick_q  <= elapsed_q;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (step) begin
						if (wake_any && (int'(n_q) < MAX_RESULTS)) begin
							n_q          <= n_q + RES_CNT_W'(1);
							pend_valid_q <= 1'b1;
							pend_task_q  <= wake_task;
							pend_prio_q  <= wake_prio;
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_woken_q <= 1'b1;
								out_task_q  <= pend_task_q;
								out_prio_q  <= pend_prio_q;
								out_last_q  <= 1'b0;
							end else begin
								out_valid_q <= 1'b0;
							end
						end else begin
							out_valid_q <= 1'b0;
						end
						if (cell_st[MAX_TASKS-1].tok) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						// Close the tick with the held wake, or with an empty
						// result when no task woke.
						out_valid_q  <= 1'b1;
						out_woken_q  <= pend_valid_q;
						out_task_q   <= pend_valid_q ? pend_task_q : '0;
						out_prio_q   <= pend_valid_q ? pend_prio_q : '0;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign woken_valid    = out_woken_q;
	assign woken_task     = out_task_q;
	assign woken_priority = out_prio_q;
	assign last           = out_last_q;
	assign tick_count     = out_tick_q;

endmodule

`default_nettype wire

// ===== hdl/tdw_checker.sv =====
// Port-level checks of the task delay wakeup table, bound to the top level.
`default_nettype none

module tdw_checker import tdw_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [ACTION_W-1:0] action,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic                woken_valid,
	input wire logic [TASK_W-1:0]   woken_task,
	input wire logic [PRIO_W-1:0]   woken_priority,
	input wire logic                last,
	input wire logic [TICKS_W-1:0]  tick_count
);

	// A held result keeps its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(woken_task) && $stable(last)
		&& $stable(tick_count))
		else $error("result changed while stalled");

	// A sleep or set-wait transaction gives its one final result in the next cycle.
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action != ACT_TICK) |=> out_valid && last && !woken_valid)
		else $error("missing result for a non-tick transaction");

	// An empty result is always the final one and carries no task.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !woken_valid |-> last && (woken_task == '0) && (woken_priority == '0))
		else $error("malformed empty result");

	// The input is not ready at the start of a tick walk.
	a_tick_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_TICK) |=> !in_ready)
		else $error("input accepted during a tick walk");

endmodule

bind task_delay_wakeup_table_core tdw_checker u_tdw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.action         (action),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.woken_valid    (woken_valid),
	.woken_task     (woken_task),
	.woken_priority (woken_priority),
	.last           (last),
	.tick_count     (tick_count)
);

`default_nettype wire
